// ----- rtl/nearest_point_lookup_macros.svh -----
// ---------------------------------------------------------------------------
// nearest_point_lookup_macros.svh
// Assertion shorthands for the nearest point lookup RTL (used by npl_ctrl).
// ---------------------------------------------------------------------------
`ifndef NEAREST_POINT_LOOKUP_MACROS_SVH
`define NEAREST_POINT_LOOKUP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define NPL_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("nearest_point_lookup: assertion failed");

// Next-cycle implication, checked out of reset.
`define NPL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("nearest_point_lookup: assertion failed");

`endif

// ----- rtl/npl_pkg.sv -----
// ---------------------------------------------------------------------------
// npl_pkg
// Types, sizes and codes shared by the nearest point lookup modules.
// ---------------------------------------------------------------------------
`default_nettype none

package npl_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int POS_W      = 32;
    localparam int ENTRY_W    = POS_W + IDX_W;

    localparam logic [1:0] ACT_LOAD  = 2'd0;
    localparam logic [1:0] ACT_QUERY = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]              action;
        logic signed [POS_W-1:0] position;
    } t_req;

    typedef struct packed {
        logic [CNT_W-1:0] nearest_number;
        logic [1:0]       status;
    } t_rsp;

    // One table entry: position, and load number minus one.
    typedef struct packed {
        logic signed [POS_W-1:0] pos;
        logic [IDX_W-1:0]        num;
    } t_entry;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] addr;
        t_entry           data;
    } t_ram_wr;

endpackage

`default_nettype wire

// ----- rtl/npl_ram.sv -----
// ---------------------------------------------------------------------------
// npl_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module npl_ram #(
    parameter int DEPTH  = 1024,
    parameter int WIDTH  = 42,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/npl_ctrl.sv -----
// ---------------------------------------------------------------------------
// npl_ctrl
// Sequencer: sorted insertion on load, binary search on query, count reset on clear.
// ---------------------------------------------------------------------------
`default_nettype none

`include "nearest_point_lookup_macros.svh"

module npl_ctrl (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_req_valid,
    output logic                                    o_req_ready,
    input  wire npl_pkg::t_req                      i_req,
    output logic                                    o_rsp_valid,
    input  wire logic                               i_rsp_ready,
    output npl_pkg::t_rsp                           o_rsp,
    output npl_pkg::t_ram_wr                        o_ram_wr,
    output logic [npl_pkg::IDX_W-1:0]               o_ram_raddr,
    input  wire logic [npl_pkg::ENTRY_W-1:0]        i_ram_rdata
);

    localparam int IDX_W = npl_pkg::IDX_W;
    localparam int CNT_W = npl_pkg::CNT_W;
    localparam int POS_W = npl_pkg::POS_W;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_INS_RD  = 4'd1;
    localparam logic [3:0] S_INS_CMP = 4'd2;
    localparam logic [3:0] S_LB_RD   = 4'd3;
    localparam logic [3:0] S_LB_CMP  = 4'd4;
    localparam logic [3:0] S_FETCH_R = 4'd5;
    localparam logic [3:0] S_GOT_R   = 4'd6;
    localparam logic [3:0] S_FETCH_L = 4'd7;
    localparam logic [3:0] S_GOT_L   = 4'd8;
    localparam logic [3:0] S_FETCH_N = 4'd9;
    localparam logic [3:0] S_GOT_N   = 4'd10;
    localparam logic [3:0] S_DONE    = 4'd11;

    logic [3:0]              r_state,  n_state;
    logic [CNT_W-1:0]        r_count,  n_count;
    logic                    r_phase,  n_phase;
    logic signed [POS_W-1:0] r_key,    n_key;
    logic [CNT_W-1:0]        r_lo,     n_lo;
    logic [CNT_W-1:0]        r_hi,     n_hi;
    logic [IDX_W-1:0]        r_j,      n_j;
    logic signed [POS_W-1:0] r_rpos,   n_rpos;
    logic [IDX_W-1:0]        r_rnum,   n_rnum;
    logic                    r_has_r,  n_has_r;
    npl_pkg::t_rsp           r_rsp,    n_rsp;

    npl_pkg::t_entry         rd;
    npl_pkg::t_entry         new_entry;
    logic [CNT_W:0]          mid_sum;
    logic [CNT_W-1:0]        mid;
    logic [POS_W:0]          d_left;
    logic [POS_W:0]          d_right;
    logic                    pick_left;
    logic                    searching;
    logic                    full_rsp;

    assign rd  = npl_pkg::t_entry'(i_ram_rdata);
    assign mid_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid = mid_sum[CNT_W:1];

    assign new_entry.pos = r_key;
    assign new_entry.num = r_count[IDX_W-1:0];

    // Left candidate lies below the key, right one at or above it.
    assign d_left  = {r_key[POS_W-1], r_key} - {rd.pos[POS_W-1], rd.pos};
    assign d_right = {r_rpos[POS_W-1], r_rpos} - {r_key[POS_W-1], r_key};
    // Distance tie goes to the right (larger) position.
    assign pick_left = !r_has_r || (d_left < d_right);

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_phase  = r_phase;
        n_key    = r_key;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_j      = r_j;
        n_rpos   = r_rpos;
        n_rnum   = r_rnum;
        n_has_r  = r_has_r;
        n_rsp    = r_rsp;
        o_ram_wr = '0;
        o_ram_raddr = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_key = i_req.position;
                    n_rsp.nearest_number = '0;
                    n_rsp.status = npl_pkg::ST_OK;
                    unique case (i_req.action)
                        npl_pkg::ACT_LOAD: begin
                            if (r_count == CNT_W'(npl_pkg::MAX_POINTS)) begin
                                n_rsp.status = npl_pkg::ST_FULL;
                                n_state = S_DONE;
                            end else begin
                                n_j = r_count[IDX_W-1:0];
                                n_state = S_INS_RD;
                            end
                        end
                        npl_pkg::ACT_QUERY: begin
                            if (r_count == '0) begin
                                n_rsp.status = npl_pkg::ST_EMPTY;
                                n_state = S_DONE;
                            end else begin
                                n_lo = '0;
                                n_hi = r_count;
                                n_phase = 1'b0;
                                n_state = S_LB_RD;
                            end
                        end
                        npl_pkg::ACT_CLEAR: begin
                            n_count = '0;
                            n_state = S_DONE;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_INS_RD: begin
                if (r_j == '0) begin
                    o_ram_wr.we   = 1'b1;
                    o_ram_wr.addr = '0;
                    o_ram_wr.data = new_entry;
                    n_count = r_count + CNT_W'(1);
                    n_state = S_DONE;
                end else begin
                    o_ram_raddr = r_j - IDX_W'(1);
                    n_state = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                o_ram_wr.we   = 1'b1;
                o_ram_wr.addr = r_j;
                if ($signed(rd.pos) > $signed(r_key)) begin
                    // shift the larger entry up one slot
                    o_ram_wr.data = rd;
                    n_j = r_j - IDX_W'(1);
                    n_state = S_INS_RD;
                end else begin
                    o_ram_wr.data = new_entry;
                    n_count = r_count + CNT_W'(1);
                    n_state = S_DONE;
                end
            end
            S_LB_RD: begin
                if (r_lo == r_hi) begin
                    n_state = r_phase ? S_FETCH_N : S_FETCH_R;
                end else begin
                    o_ram_raddr = mid[IDX_W-1:0];
                    n_state = S_LB_CMP;
                end
            end
            S_LB_CMP: begin
                if ($signed(rd.pos) < $signed(r_key)) begin
                    n_lo = mid + CNT_W'(1);
                end else begin
                    n_hi = mid;
                end
                n_state = S_LB_RD;
            end
            S_FETCH_R: begin
                if (r_lo != r_count) begin
                    o_ram_raddr = r_lo[IDX_W-1:0];
                    n_has_r = 1'b1;
                    n_state = S_GOT_R;
                end else begin
                    n_has_r = 1'b0;
                    n_state = S_FETCH_L;
                end
            end
            S_GOT_R: begin
                n_rpos = rd.pos;
                n_rnum = rd.num;
                n_state = S_FETCH_L;
            end
            S_FETCH_L: begin
                if (r_lo != '0) begin
                    o_ram_raddr = r_lo[IDX_W-1:0] - IDX_W'(1);
                    n_state = S_GOT_L;
                end else begin
                    n_rsp.nearest_number = {1'b0, r_rnum} + CNT_W'(1);
                    n_state = S_DONE;
                end
            end
            S_GOT_L: begin
                if (pick_left) begin
                    // find the first entry at the left position
                    n_key   = rd.pos;
                    n_lo    = '0;
                    n_hi    = r_lo - CNT_W'(1);
                    n_phase = 1'b1;
                    n_state = S_LB_RD;
                end else begin
                    n_rsp.nearest_number = {1'b0, r_rnum} + CNT_W'(1);
                    n_state = S_DONE;
                end
            end
            S_FETCH_N: begin
                o_ram_raddr = r_lo[IDX_W-1:0];
                n_state = S_GOT_N;
            end
            S_GOT_N: begin
                n_rsp.nearest_number = {1'b0, rd.num} + CNT_W'(1);
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_rsp_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_phase <= n_phase;
        r_key   <= n_key;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_j     <= n_j;
        r_rpos  <= n_rpos;
        r_rnum  <= n_rnum;
        r_has_r <= n_has_r;
        r_rsp   <= n_rsp;
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = (r_state == S_DONE);
    assign o_rsp       = r_rsp;

    assign searching = (r_state == S_LB_RD) || (r_state == S_LB_CMP);
    assign full_rsp  = o_rsp_valid && (r_rsp.status == npl_pkg::ST_FULL);

    `NPL_ASSERT_IMPL(a_count_le_max, 1'b1, r_count <= CNT_W'(npl_pkg::MAX_POINTS))
    `NPL_ASSERT_IMPL(a_wr_in_table, o_ram_wr.we, CNT_W'(o_ram_wr.addr) <= r_count)
    `NPL_ASSERT_IMPL(a_search_bounds, searching, (r_lo <= r_hi) && (r_hi <= r_count))
    `NPL_ASSERT_IMPL(a_full_only_at_max, full_rsp, r_count == CNT_W'(npl_pkg::MAX_POINTS))

endmodule

`default_nettype wire

// ----- rtl/npl_out_buf.sv -----
// ---------------------------------------------------------------------------
// npl_out_buf
// One-entry output register between the sequencer and the result channel.
// ---------------------------------------------------------------------------
`default_nettype none

module npl_out_buf (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire npl_pkg::t_rsp i_rsp,
    output logic               o_valid,
    input  wire logic          i_ready,
    output npl_pkg::t_rsp      o_rsp
);

    logic          r_valid;
    npl_pkg::t_rsp r_rsp;

    // take a new result whenever the slot is empty or draining
    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_rsp <= i_rsp;
        end
    end

    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

endmodule

`default_nettype wire

// ----- rtl/nearest_point_lookup.sv -----
// ---------------------------------------------------------------------------
// nearest_point_lookup
// Point table with sorted insertion and nearest-position binary search.
// ---------------------------------------------------------------------------
// Requests arrive on i_valid/o_ready/i_req (action, position); every request
// gives exactly one result on o_valid/i_ready/o_rsp (nearest_number, status).
// The table is held sorted by position (then load number) in one RAM with a
// registered read; a single sequencer handles one request at a time.
// Request handling, from accept to result:
//   clear, unused action, full load, empty query: answered directly.
//   load: a read-compare-write shift moves each stored entry with a larger
//   position up one slot, then the new entry is written into the freed slot.
//   query: one binary search over the table, plus a second one over the
//   lower part when the lower neighbor wins.
// A finished result sits in an output register, so the next request is taken
// while that result waits. If the receiver holds i_ready low, the sequencer
// stalls with its next result once that register is full.
// Reset empties the table at once (the entry count clears); stored entries
// are not cleared and are never read beyond the count.
// ---------------------------------------------------------------------------
`default_nettype none

module nearest_point_lookup (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire npl_pkg::t_req i_req,
    output logic               o_valid,
    input  wire logic          i_ready,
    output npl_pkg::t_rsp      o_rsp
);

    npl_pkg::t_ram_wr                ram_wr;
    logic [npl_pkg::IDX_W-1:0]       ram_raddr;
    logic [npl_pkg::ENTRY_W-1:0]     ram_rdata;
    logic                            rsp_valid;
    logic                            rsp_ready;
    npl_pkg::t_rsp                   rsp;

    npl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_valid),
        .o_req_ready (o_ready),
        .i_req       (i_req),
        .o_rsp_valid (rsp_valid),
        .i_rsp_ready (rsp_ready),
        .o_rsp       (rsp),
        .o_ram_wr    (ram_wr),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );

    npl_ram #(
        .DEPTH  (npl_pkg::MAX_POINTS),
        .WIDTH  (npl_pkg::ENTRY_W),
        .ADDR_W (npl_pkg::IDX_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_wr.we),
        .i_waddr (ram_wr.addr),
        .i_wdata (ram_wr.data),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    npl_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (rsp_valid),
        .o_ready (rsp_ready),
        .i_rsp   (rsp),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_rsp   (o_rsp)
    );

endmodule

`default_nettype wire
